// ===== rtl/core/fmtm_pkg.sv =====
// ----------------------------------------------------------------------------
// fmtm_pkg
// widths and curve constants shared by the filmic tone map pipeline
// ----------------------------------------------------------------------------
package fmtm_pkg;

    localparam int ChW  = 24;
    localparam int YW   = 20;
    localparam int YYW  = 40;
    localparam int AW   = 47;
    localparam int NW   = 64;
    localparam int QW   = 17;
    localparam int OW   = 17;
    localparam int DivStages = QW;
    localparam int PolyStages = 3;
    localparam int Depth = PolyStages + DivStages + 1;

    // curve folded to integers: num 42y^2+327680y, den 45y^2+9830400y+18*2^32
    localparam logic [24:0]   WhiteY  = 25'd734004;
    localparam logic [AW-1:0] NumA    = AW'(42);
    localparam logic [AW-1:0] NumB    = AW'(327680);
    localparam logic [AW-1:0] DenA    = AW'(45);
    localparam logic [AW-1:0] DenB    = AW'(9830400);
    localparam logic [AW-1:0] DenC    = AW'(64'd18 << 32);
    localparam logic [NW-1:0] WsNum   = NW'(91785);
    localparam logic [NW-1:0] WsDen   = NW'(66556);
    localparam logic [OW-1:0] QOne    = OW'(65536);

endpackage

// ===== rtl/core/fmtm_poly.sv =====
// ----------------------------------------------------------------------------
// fmtm_poly
// three stage evaluation of numerator and denominator of the scaled curve
// ----------------------------------------------------------------------------
module fmtm_poly
    import fmtm_pkg::*;
(
    input  logic            clk,
    input  logic            en,
    input  logic [ChW-1:0]  x,
    output logic [NW-1:0]   num,
    output logic [NW-1:0]   den,
    output logic            sat
);

    logic [24:0]    y2;
    logic [YW-1:0]  y_reg;
    logic [YYW-1:0] yy_reg;
    logic           sat1_reg;
    logic [AW-1:0]  a_reg;
    logic [AW-1:0]  b_reg;
    logic           sat2_reg;
    logic [NW-1:0]  n_reg;
    logic [NW-1:0]  d_reg;
    logic           sat3_reg;
    logic [AW-1:0]  a_next;
    logic [AW-1:0]  b_next;

    assign y2 = {x, 1'b0};

    always_comb
    begin
        a_next = NumA * AW'(yy_reg) + NumB * AW'(y_reg);
        b_next = DenA * AW'(yy_reg) + DenB * AW'(y_reg) + DenC;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg    <= y2[YW-1:0];
            yy_reg   <= YYW'(y2[YW-1:0]) * YYW'(y2[YW-1:0]);
            sat1_reg <= (y2 >= WhiteY);
            a_reg    <= a_next;
            b_reg    <= b_next;
            sat2_reg <= sat1_reg;
            n_reg    <= NW'(a_reg) * WsNum;
            d_reg    <= NW'(b_reg) * WsDen;
            sat3_reg <= sat2_reg;
        end
    end

    assign num = n_reg;
    assign den = d_reg;
    assign sat = sat3_reg;

endmodule

// ===== rtl/core/fmtm_div.sv =====
// ----------------------------------------------------------------------------
// fmtm_div
// pipelined restoring division, one quotient bit per stage, then rounding
// ----------------------------------------------------------------------------
module fmtm_div
    import fmtm_pkg::*;
(
    input  logic           clk,
    input  logic           en,
    input  logic [NW-1:0]  num,
    input  logic [NW-1:0]  den,
    input  logic           sat,
    output logic [OW-1:0]  res
);

    logic [NW-1:0] r_reg   [DivStages];
    logic [NW-1:0] d_reg   [DivStages];
    logic [QW-1:0] q_reg   [DivStages];
    logic          sat_reg [DivStages];
    logic [OW-1:0] res_reg;
    logic [QW:0]   qr;
    logic [OW-1:0] rnd;

    genvar k;
    generate
        for (k = 0; k < DivStages; k++)
        begin : g_stage
            logic [NW-1:0] r_prev;
            logic [NW-1:0] d_prev;
            logic [QW-1:0] q_prev;
            logic          s_prev;
            logic [NW-1:0] r_sh;
            logic          take;

            if (k == 0)
            begin : g_first
                assign r_prev = num;
                assign d_prev = den;
                assign q_prev = '0;
                assign s_prev = sat;
            end
            else
            begin : g_rest
                assign r_prev = r_reg[k-1];
                assign d_prev = d_reg[k-1];
                assign q_prev = q_reg[k-1];
                assign s_prev = sat_reg[k-1];
            end

            assign r_sh = {r_prev[NW-2:0], 1'b0};
            assign take = (r_sh >= d_prev);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k]   <= take ? (r_sh - d_prev) : r_sh;
                    d_reg[k]   <= d_prev;
                    q_reg[k]   <= {q_prev[QW-2:0], take};
                    sat_reg[k] <= s_prev;
                end
            end
        end
    endgenerate

    // round half up, then saturate to 1.0
    assign qr  = {1'b0, q_reg[DivStages-1]} + (QW+1)'(1);
    assign rnd = qr[QW:1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= (sat_reg[DivStages-1] || rnd > QOne) ? QOne : rnd;
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/core/filmic_tonemap_pixel.sv =====
// Filmic tone map of one HDR pixel per item: each Q8.16 channel is doubled,
// run through the rational filmic curve, scaled by the white point and given
// as Q1.16 saturated to 1.0. The pipeline takes one item every clock cycle
// unless the output stalls; it has three stages for the curve polynomials and
// their scaling, seventeen for the bit-per-stage divider and one for rounding.
// A stall at the output holds the whole pipeline; in_ready is low only while
// a result waits and out_ready is low.
// ----------------------------------------------------------------------------
// filmic_tonemap_pixel
// top level: three channel pipelines sharing one valid chain
// ----------------------------------------------------------------------------
module filmic_tonemap_pixel
    import fmtm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [ChW-1:0]  red_in,
    input  logic [ChW-1:0]  green_in,
    input  logic [ChW-1:0]  blue_in,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [OW-1:0]   red_out,
    output logic [OW-1:0]   green_out,
    output logic [OW-1:0]   blue_out
);

    logic [Depth-1:0] vld_reg;
    logic [Depth-1:0] vld_next;
    logic             en;
    logic [ChW-1:0]   ch_in  [3];
    logic [OW-1:0]    ch_out [3];

    assign en       = !vld_reg[Depth-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[Depth-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign ch_in[0] = red_in;
    assign ch_in[1] = green_in;
    assign ch_in[2] = blue_in;

    genvar c;
    generate
        for (c = 0; c < 3; c++)
        begin : g_ch
            logic [NW-1:0] num;
            logic [NW-1:0] den;
            logic          sat;

            fmtm_poly u_poly (
                .clk (clk),
                .en  (en),
                .x   (ch_in[c]),
                .num (num),
                .den (den),
                .sat (sat)
            );

            fmtm_div u_div (
                .clk (clk),
                .en  (en),
                .num (num),
                .den (den),
                .sat (sat),
                .res (ch_out[c])
            );
        end
    endgenerate

    assign out_valid = vld_reg[Depth-1];
    assign red_out   = ch_out[0];
    assign green_out = ch_out[1];
    assign blue_out  = ch_out[2];

endmodule

// ===== rtl/core/fmtm_checker.sv =====
// ----------------------------------------------------------------------------
// fmtm_checker
// port level checks of the tone map pipeline
// ----------------------------------------------------------------------------
module fmtm_checker
    import fmtm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_ready,
    input  logic            out_valid,
    input  logic            out_ready,
    input  logic [OW-1:0]   red_out,
    input  logic [OW-1:0]   green_out,
    input  logic [OW-1:0]   blue_out
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out)
            && $stable(green_out) && $stable(blue_out))
        else $error("stalled item changed");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> red_out <= QOne && green_out <= QOne && blue_out <= QOne)
        else $error("result above 1.0");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output drains");

endmodule

bind filmic_tonemap_pixel fmtm_checker u_fmtm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
);

// ===== tb/filmic_tonemap_pixel_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// filmic_tonemap_pixel_test
// streams pixels through the filmic tone map under random bursts, gaps and
// output stalls, and compares every mapped pixel with a bit-exact prediction
// of the rational curve, white point scaling, rounding and saturation
// ----------------------------------------------------------------------------
module filmic_tonemap_pixel_test;
    import fmtm_pkg::*;

    typedef struct packed {
        logic [OW-1:0] red;
        logic [OW-1:0] green;
        logic [OW-1:0] blue;
    } mapped_pixel_t;

    function automatic logic [OW-1:0] tone_channel(input logic [ChW-1:0] x);
        logic [63:0] y;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        logic [63:0] rem;
        y = 64'(x) * 2;
        if (y >= 64'd734004)
            return OW'(65536);
        num = (42 * y * y + 327680 * y) * 64'd91785;
        den = (45 * y * y + 9830400 * y + (64'd18 << 32)) * 64'd66556;
        quo = num / den;
        rem = num % den;
        for (int i = 0; i < 17; i++)
        begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        quo = (quo + 1) >> 1;
        if (quo > 64'd65536)
            quo = 64'd65536;
        return quo[OW-1:0];
    endfunction

    class pixel_scoreboard;
        mapped_pixel_t pending[$];
        int errors = 0;

        function void note_pixel(logic [ChW-1:0] r, logic [ChW-1:0] g, logic [ChW-1:0] b);
            mapped_pixel_t p;
            p.red = tone_channel(r);
            p.green = tone_channel(g);
            p.blue = tone_channel(b);
            pending.push_back(p);
        endfunction

        function void check_pixel(logic [OW-1:0] r, logic [OW-1:0] g, logic [OW-1:0] b);
            mapped_pixel_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected pixel %0d %0d %0d", r, g, b);
                return;
            end
            want = pending.pop_front();
            if (want.red !== r || want.green !== g || want.blue !== b)
            begin
                errors++;
                if (errors <= 10)
                    $display("pixel mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                             want.red, want.green, want.blue, r, g, b);
            end
        endfunction
    endclass

    logic          clk = 0;
    logic          rst_n = 0;
    logic          in_valid = 0;
    logic          in_ready;
    logic [ChW-1:0] red_in = '0;
    logic [ChW-1:0] green_in = '0;
    logic [ChW-1:0] blue_in = '0;
    logic          out_valid;
    logic          out_ready = 0;
    logic [OW-1:0] red_out;
    logic [OW-1:0] green_out;
    logic [OW-1:0] blue_out;

    pixel_scoreboard sb = new();

    filmic_tonemap_pixel u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_pixel(red_in, green_in, blue_in);
        if (rst_n && out_valid && out_ready)
            sb.check_pixel(red_out, green_out, blue_out);
    end

    // receiver stall pattern: phases of always ready, random, mostly stalled
    int stall_mode = 0;
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end
        stall_left--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    int burst_left = 0;

    task automatic send_pixel(input logic [ChW-1:0] r, input logic [ChW-1:0] g,
                              input logic [ChW-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        else
            @(negedge clk);
        burst_left--;
        in_valid = 1'b1;
        red_in = r;
        green_in = g;
        blue_in = b;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [ChW-1:0] rand_channel();
        case ($urandom_range(0, 4))
            0: return ChW'($urandom);
            1: return ChW'($urandom_range(0, 255));
            2: return ChW'($urandom_range(367000, 367004));
            default: return ChW'($urandom_range(0, 367001));
        endcase
    endfunction

    initial
    begin
        logic [ChW-1:0] edge_vals[12];
        edge_vals = '{24'd0, 24'd1, 24'd2, 24'hFFFFFF, 24'd367001, 24'd367002,
                      24'd367003, 24'h800000, 24'h555555, 24'hAAAAAA, 24'd65536,
                      24'd32768};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (edge_vals[i])
            send_pixel(edge_vals[i], edge_vals[(i + 4) % 12], edge_vals[(i + 8) % 12]);
        for (int i = 0; i < 600; i++)
            send_pixel(rand_channel(), rand_channel(), rand_channel());
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.errors++;
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
